[rtl/sfr_pkg.sv]
`timescale 1ns / 1ps
package sfr_pkg;

	localparam int MAX_DISTINCT_DEF = 64;
	localparam int COUNT_BITS_DEF   = 32;
	localparam int NSYM             = 256;
	localparam int SYM_W            = 8;
	localparam int OCC_W            = 32;
	localparam int PROB_W           = 17;
	localparam int FRAC_STEPS       = 16;
	localparam int DIST_W           = 9;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_SCAN,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                 we;
		logic [SYM_W-1:0]     waddr;
		logic [SYM_W-1:0]     raddr;
	} ram_ctrl_t;

endpackage

[rtl/sfr_count_ram.sv]
`timescale 1ns / 1ps
module sfr_count_ram #(
	parameter int COUNT_BITS = sfr_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  sfr_pkg::ram_ctrl_t    ctrl,
	input  logic [COUNT_BITS-1:0] wdata,
	output logic [COUNT_BITS-1:0] rdata
);

	logic [COUNT_BITS-1:0] mem [sfr_pkg::NSYM];

	always_ff @(posedge clk) begin
		if (ctrl.we) begin
			mem[ctrl.waddr] <= wdata;
		end
		rdata <= mem[ctrl.raddr];
	end

endmodule

[rtl/symbol_frequency_ranker.sv]
`timescale 1ns / 1ps
// Channel | Dir | Fields (tdata from bit 0 up)                      | tuser            | tlast
// s_axis  | in  | symbol[7:0]                                       | -                | last
// m_axis  | out | symbol_out[7:0] occurrences[39:8] probability[56:40] | too_many_symbols | end_of_list
//
// A byte passes through the accept in idle, one read and one write of the count RAM;
// s_tready is high only in idle.
// After the last byte, each ranked entry takes a scan over the count RAM (one read
// port, one symbol a cycle) and a restoring division, then waits for m_tready.
// A message of n distinct symbols yields n ranked entries (n capped at MAX_DISTINCT).
// arst_n clears all control state; per-symbol valid bits stand in for clearing the RAM,
// so the block is ready right after reset and right after the final entry of a list.
module symbol_frequency_ranker #(
	parameter int MAX_DISTINCT = sfr_pkg::MAX_DISTINCT_DEF,
	parameter int COUNT_BITS   = sfr_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // symbol[7:0]
	input  logic        s_tlast,   // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // symbol_out[7:0], occurrences[39:8], probability[56:40]
	output logic        m_tuser,   // too_many_symbols
	output logic        m_tlast    // end_of_list
);

	localparam int SW    = sfr_pkg::SYM_W;
	localparam int CW    = COUNT_BITS;
	localparam int RW    = $clog2(MAX_DISTINCT + 1);
	localparam int DCW   = $clog2(sfr_pkg::FRAC_STEPS + 1);
	localparam int SCW   = SW + 1;
	localparam int PW    = sfr_pkg::PROB_W;
	localparam int OW    = sfr_pkg::OCC_W;
	localparam int DW    = sfr_pkg::DIST_W;

	sfr_pkg::state_t state_q, state_d;
	sfr_pkg::ram_ctrl_t ram_ctrl;

	logic [SW-1:0]            sym_q;
	logic                     last_q;
	logic [CW-1:0]            total_q;
	logic [DW-1:0]            distinct_q;
	logic [sfr_pkg::NSYM-1:0] valid_q;
	logic [sfr_pkg::NSYM-1:0] taken_q;
	logic [SCW-1:0]           scan_q;
	logic                     cmp_s1;
	logic [SW-1:0]            cmp_sym_s1;
	logic [CW-1:0]            best_cnt_q;
	logic [SW-1:0]            best_sym_q;
	logic [CW:0]              rem_q;
	logic [PW-1:0]            quo_q;
	logic [DCW-1:0]           div_cnt_q;
	logic [RW-1:0]            rank_q;
	logic [CW-1:0]            rd_data;
	logic [CW-1:0]            wr_data;
	logic [CW-1:0]            cur_cnt;
	logic [CW-1:0]            scan_cnt;
	logic                     cut;
	logic [RW-1:0]            n_lim;
	logic                     list_end;
	logic [CW:0]              rem_sh;
	logic [CW+OW-1:0]         occ_ext;
	logic [OW-1:0]            occ;
	logic                     scan_done;
	logic                     div_done;

	sfr_count_ram #(.COUNT_BITS(CW)) u_ram (
		.clk   (clk),
		.ctrl  (ram_ctrl),
		.wdata (wr_data),
		.rdata (rd_data)
	);

	// Entries not marked valid read as zero; this replaces a clearing pass.
	assign cur_cnt   = valid_q[sym_q] ? rd_data : '0;
	assign scan_cnt  = (valid_q[cmp_sym_s1] && !taken_q[cmp_sym_s1]) ? rd_data : '0;
	assign wr_data   = (cur_cnt == {CW{1'b1}}) ? cur_cnt : cur_cnt + CW'(1);
	assign cut       = distinct_q > DW'(MAX_DISTINCT);
	assign n_lim     = cut ? RW'(MAX_DISTINCT) : RW'(distinct_q);
	assign list_end  = (rank_q + RW'(1)) == n_lim;
	assign scan_done = scan_q == SCW'(sfr_pkg::NSYM);
	assign div_done  = div_cnt_q == DCW'(sfr_pkg::FRAC_STEPS);
	assign rem_sh    = {rem_q[CW-1:0], 1'b0};

	// Clamp wide counts for the occurrences field.
	assign occ_ext = {{OW{1'b0}}, best_cnt_q};
	assign occ     = (|occ_ext[CW+OW-1:OW]) ? {OW{1'b1}} : occ_ext[OW-1:0];

	assign m_tdata = {{(64 - SW - OW - PW){1'b0}}, quo_q, occ, best_sym_q};
	assign m_tuser = cut;
	assign m_tlast = list_end;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sfr_pkg::ST_IDLE:   if (s_tvalid) state_d = sfr_pkg::ST_ACC_RD;
			sfr_pkg::ST_ACC_RD: state_d = sfr_pkg::ST_ACC_WR;
			sfr_pkg::ST_ACC_WR: state_d = last_q ? sfr_pkg::ST_SCAN : sfr_pkg::ST_IDLE;
			sfr_pkg::ST_SCAN:   if (scan_done) state_d = sfr_pkg::ST_DIV;
			sfr_pkg::ST_DIV:    if (div_done) state_d = sfr_pkg::ST_OUT;
			sfr_pkg::ST_OUT: begin
				if (m_tready) state_d = list_end ? sfr_pkg::ST_IDLE : sfr_pkg::ST_SCAN;
			end
			default:            state_d = sfr_pkg::ST_IDLE;
		endcase
	end

	// Outputs and RAM control
	always_comb begin
		s_tready       = 1'b0;
		m_tvalid       = 1'b0;
		ram_ctrl.we    = 1'b0;
		ram_ctrl.waddr = sym_q;
		ram_ctrl.raddr = sym_q;
		unique case (state_q)
			sfr_pkg::ST_IDLE:   s_tready = 1'b1;
			sfr_pkg::ST_ACC_RD: ram_ctrl.raddr = sym_q;
			sfr_pkg::ST_ACC_WR: ram_ctrl.we = 1'b1;
			sfr_pkg::ST_SCAN:   ram_ctrl.raddr = scan_q[SW-1:0];
			sfr_pkg::ST_DIV:    ram_ctrl.raddr = sym_q;
			sfr_pkg::ST_OUT:    m_tvalid = 1'b1;
			default:            s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sfr_pkg::ST_IDLE;
			total_q    <= '0;
			distinct_q <= '0;
			valid_q    <= '0;
			taken_q    <= '0;
			cmp_s1     <= 1'b0;
			rank_q     <= '0;
			scan_q     <= '0;
			div_cnt_q  <= '0;
		end else begin
			state_q <= state_d;
			cmp_s1  <= (state_q == sfr_pkg::ST_SCAN) && !scan_done;
			unique case (state_q)
				sfr_pkg::ST_IDLE: begin
					rank_q <= '0;
				end
				sfr_pkg::ST_ACC_WR: begin
					valid_q[sym_q] <= 1'b1;
					if (cur_cnt == '0) distinct_q <= distinct_q + DW'(1);
					if (total_q != {CW{1'b1}}) total_q <= total_q + CW'(1);
					scan_q <= '0;
				end
				sfr_pkg::ST_SCAN: begin
					if (!scan_done) scan_q <= scan_q + SCW'(1);
					div_cnt_q <= '0;
				end
				sfr_pkg::ST_DIV: begin
					if (!div_done) div_cnt_q <= div_cnt_q + DCW'(1);
				end
				sfr_pkg::ST_OUT: begin
					scan_q <= '0;
					if (m_tready) begin
						// Drop the whole histogram after the final entry.
						if (list_end) begin
							valid_q    <= '0;
							taken_q    <= '0;
							total_q    <= '0;
							distinct_q <= '0;
						end else begin
							taken_q[best_sym_q] <= 1'b1;
							rank_q              <= rank_q + RW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload: input hold, best-so-far search and restoring division
	always_ff @(posedge clk) begin
		if (state_q == sfr_pkg::ST_IDLE) begin
			sym_q  <= s_tdata[SW-1:0];
			last_q <= s_tlast;
		end
		cmp_sym_s1 <= scan_q[SW-1:0];
		// Start each scan from zero; hold the best entry while it is offered.
		if (cmp_s1 && scan_cnt > best_cnt_q) begin
			best_cnt_q <= scan_cnt;
			best_sym_q <= cmp_sym_s1;
		end else if (state_q == sfr_pkg::ST_ACC_WR ||
				(state_q == sfr_pkg::ST_OUT && m_tready)) begin
			best_cnt_q <= '0;
		end
		if (state_q == sfr_pkg::ST_DIV) begin
			if (div_cnt_q == '0) begin
				// Count never exceeds total, so the integer part is 0 or 1.
				if ({1'b0, best_cnt_q} >= {1'b0, total_q}) begin
					quo_q <= PW'(1);
					rem_q <= {1'b0, best_cnt_q} - {1'b0, total_q};
				end else begin
					quo_q <= '0;
					rem_q <= {1'b0, best_cnt_q};
				end
			end else begin
				if (rem_sh >= {1'b0, total_q}) begin
					rem_q <= rem_sh - {1'b0, total_q};
					quo_q <= {quo_q[PW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[PW-2:0], 1'b0};
				end
			end
		end
	end

	// The ranker never offers a result while it takes bytes.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_tvalid && s_tready))
		else $error("result offered while input is open");

	// An offered entry stays within the list length.
	a_rank_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (rank_q < n_lim))
		else $error("rank beyond list length");

	// A result is never a symbol with zero count.
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (best_cnt_q != '0))
		else $error("zero count ranked");

endmodule

[bench/sfr_ranking_checker.sv]
`timescale 1ns / 1ps
module sfr_ranking_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic        m_tuser,
	input  logic        m_tlast,
	output int          mismatches,
	output int          entries_waiting,
	output int          entries_seen,
	output int          lists_closed
);

	localparam int          RANK_LIMIT = sfr_pkg::MAX_DISTINCT_DEF;
	localparam logic [31:0] CNT_SAT    = 32'hFFFF_FFFF;

	typedef struct {
		logic [sfr_pkg::SYM_W-1:0]  sym;
		logic [sfr_pkg::OCC_W-1:0]  occ;
		logic [sfr_pkg::PROB_W-1:0] prob;
		logic                       cut;
		logic                       eol;
	} rank_entry_t;

	logic [31:0]  byte_count [sfr_pkg::NSYM];
	logic [31:0]  msg_length;
	int           distinct_syms;
	rank_entry_t  ranked_q [$];

	function automatic logic [sfr_pkg::PROB_W-1:0] q16_share(logic [31:0] c, logic [31:0] t);
		longint unsigned num;
		num = longint'(c) << 16;
		return sfr_pkg::PROB_W'(num / longint'(t));
	endfunction

	// Count the byte; on the last one rank the symbols and clear for the next message.
	task automatic take_byte(logic [7:0] sym, logic is_last);
		bit          taken [sfr_pkg::NSYM];
		int          n;
		int          best;
		logic [31:0] best_cnt;
		rank_entry_t e;
		if (byte_count[sym] == 0) distinct_syms++;
		if (byte_count[sym] != CNT_SAT) byte_count[sym]++;
		if (msg_length != CNT_SAT) msg_length++;
		if (!is_last) return;
		n = (distinct_syms > RANK_LIMIT) ? RANK_LIMIT : distinct_syms;
		foreach (taken[s]) taken[s] = 0;
		for (int k = 0; k < n; k++) begin
			best = -1;
			best_cnt = 0;
			for (int s = 0; s < sfr_pkg::NSYM; s++) begin
				if (!taken[s] && byte_count[s] > best_cnt) begin
					best = s;
					best_cnt = byte_count[s];
				end
			end
			taken[best] = 1;
			e.sym  = sfr_pkg::SYM_W'(best);
			e.occ  = best_cnt;
			e.prob = q16_share(best_cnt, msg_length);
			e.cut  = distinct_syms > RANK_LIMIT;
			e.eol  = (k == n - 1);
			ranked_q.push_back(e);
		end
		foreach (byte_count[s]) byte_count[s] = 0;
		msg_length = 0;
		distinct_syms = 0;
	endtask

	always @(posedge clk) begin
		rank_entry_t e;
		if (!arst_n) begin
			// Clear the model while the block is held in reset.
			foreach (byte_count[s]) byte_count[s] = 0;
			msg_length = 0;
			distinct_syms = 0;
			ranked_q.delete();
			mismatches = 0;
			entries_seen = 0;
			lists_closed = 0;
		end else begin
			if (s_tvalid && s_tready) take_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				entries_seen++;
				if (ranked_q.size() == 0) begin
					$error("unexpected ranked word: tdata=%h", m_tdata);
					mismatches++;
				end else begin
					e = ranked_q.pop_front();
					if (m_tdata[7:0] !== e.sym) begin
						$error("symbol_out: expected %0d, got %0d", e.sym, m_tdata[7:0]);
						mismatches++;
					end
					if (m_tdata[39:8] !== e.occ) begin
						$error("occurrences: expected %0d, got %0d", e.occ, m_tdata[39:8]);
						mismatches++;
					end
					if (m_tdata[56:40] !== e.prob) begin
						$error("probability: expected %0d, got %0d", e.prob, m_tdata[56:40]);
						mismatches++;
					end
					if (m_tuser !== e.cut) begin
						$error("too_many_symbols: expected %0d, got %0d", e.cut, m_tuser);
						mismatches++;
					end
					if (m_tlast !== e.eol) begin
						$error("end_of_list: expected %0d, got %0d", e.eol, m_tlast);
						mismatches++;
					end
					if (e.eol) lists_closed++;
				end
			end
		end
		entries_waiting = ranked_q.size();
	end

endmodule

[bench/tb_symbol_frequency_ranker.sv]
`timescale 1ns / 1ps
module tb_symbol_frequency_ranker;
	localparam int RANDOM_BYTES = 110;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 600;   // one full entry (scan + divide) with margin
	localparam int HOLD_CYCLES  = 3000;  // long receiver hold-off

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // symbol[7:0]
	logic        s_tlast;   // last
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // symbol_out[7:0], occurrences[39:8], probability[56:40]
	logic        m_tuser;   // too_many_symbols
	logic        m_tlast;   // end_of_list

	int mismatches;
	int entries_waiting;
	int entries_seen;
	int lists_closed;
	int bytes_sent;
	int cycles;

	symbol_frequency_ranker dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	sfr_ranking_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.mismatches(mismatches), .entries_waiting(entries_waiting),
		.entries_seen(entries_seen), .lists_closed(lists_closed)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Watchdog: abort a hung run.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Pick a gap: mostly none or short, now and then long.
	function automatic int pick_gap();
		if ($urandom_range(0, 2) == 0) return 0;
		if ($urandom_range(0, 11) == 0) return $urandom_range(20, 80);
		return $urandom_range(1, 3);
	endfunction

	// Offer one word and hold it until the block takes it.
	task automatic send_byte(logic [7:0] sym, logic is_last, bit may_idle);
		int gap;
		gap = may_idle ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= sym;
		s_tlast  <= is_last;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	// Receiver: one long hold-off on the first list, then random stalls.
	initial begin
		int run;
		m_tready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk iff m_tvalid);
		repeat (HOLD_CYCLES) @(posedge clk);
		forever begin
			m_tready <= 1'b1;
			run = $urandom_range(0, 3) == 0 ? $urandom_range(30, 120) : $urandom_range(1, 8);
			repeat (run) @(posedge clk);
			run = pick_gap();
			if (run > 0) begin
				m_tready <= 1'b0;
				repeat (run) @(posedge clk);
			end
		end
	end

	// Stimulus
	initial begin
		int len;
		int base;
		int span;
		logic [7:0] sym;
		bytes_sent = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: sender keeps offering while the receiver holds off, so the
		// block stalls its input behind the first ranked list.
		send_byte(8'h00, 1'b1, 0);                 // lone byte: full share
		send_byte(8'hFF, 1'b1, 0);                 // next message right behind it
		for (int i = 0; i < 4; i++) send_byte(8'hFF, 1'b0, 0);
		send_byte(8'hFF, 1'b1, 0);                 // one symbol repeated
		send_byte(8'h05, 1'b0, 1);                 // ties resolve by ascending symbol
		send_byte(8'h03, 1'b0, 1);
		send_byte(8'h05, 1'b0, 1);
		send_byte(8'h03, 1'b0, 1);
		send_byte(8'h07, 1'b1, 1);
		send_byte(8'hAA, 1'b0, 1);                 // sevenths: shares round down
		send_byte(8'h55, 1'b0, 1);
		send_byte(8'hAA, 1'b0, 1);
		send_byte(8'h55, 1'b0, 1);
		send_byte(8'h01, 1'b0, 1);
		send_byte(8'h80, 1'b0, 1);
		send_byte(8'h80, 1'b1, 1);

		// Over the distinct limit: the list is cut and flagged.
		len = $urandom_range(65, 70);
		base = $urandom_range(0, 255);
		for (int i = 0; i < len; i++)
			send_byte(8'(base + i * 3 + (i % 2)), i == len - 1, 1);

		// Random messages, mostly short with a small alphabet.
		while (bytes_sent < RANDOM_BYTES) begin
			len  = $urandom_range(0, 5) == 0 ? $urandom_range(9, 20) : $urandom_range(1, 8);
			base = $urandom_range(0, 255);
			span = $urandom_range(0, 2) == 0 ? 255 : $urandom_range(1, 4);
			for (int i = 0; i < len; i++) begin
				sym = span == 255 ? 8'($urandom_range(0, 255)) : 8'(base + $urandom_range(0, span));
				send_byte(sym, i == len - 1, 1);
			end
		end
		s_tvalid <= 1'b0;

		// Let the checker take the last byte before waiting on its queue.
		@(posedge clk);
		while (entries_waiting != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes; checked %0d ranked entries over %0d lists.",
			bytes_sent, entries_seen, lists_closed);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
